FILE: rtl/core/bsq_pkg.sv
// Package for the beam steering phase quantizer.
// Holds payload structs, queue entry type and register codes; no dependencies.
package bsq_pkg;

  localparam int SPACING_W   = 20;
  localparam int DIR_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int PHASE_W     = 31;
  localparam int MAX_RESULTS = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SPACING_W-1:0] SPACING_RESET = 20'd32768;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Y = 2'd1;

  localparam logic signed [32:0] UNIT_MAG_SQ = 33'sd1073741824;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_u;
    logic signed [DIR_W-1:0] dir_v;
  } bsq_in_t;

  typedef struct packed {
    logic [3:0] element_index;
    logic [3:0] phase_code;
    logic       rejected;
    logic       last_element;
  } bsq_out_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_u;
    logic signed [DIR_W-1:0] dir_v;
    logic                    rejected;
  } bsq_cmd_t;

endpackage

FILE: rtl/core/beam_steering_phase_quantizer_top.sv
// Top level of the beam steering phase quantizer: spacing registers, front end,
// command queue and element sequencer. Depends on bsq_pkg, bsq_front, bsq_queue, bsq_back.
//
// Usage:
//   Input: a direction (dir_u, dir_v) is transferred on a rising edge with start high
//   and busy low. busy rises only when the front stage holds a direction and the
//   two-entry command queue is full.
//   Output: each result is on out_data for one cycle with out_valid high; the receiver
//   cannot stall. A direction outside the unit circle gives one rejected result;
//   otherwise min(ARRAY_ROWS*ARRAY_COLS, 16) results in row-major order, last flagged.
//   Path: the first result passes the square stage, the queue, the step multiply and the
//   output register.
//   Throughput: one result per cycle; a direction holds the sequencer until its last result.
//   Bursts of successive directions follow each other without a gap when the next
//   direction is already in the queue.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index (0 column spacing,
//   1 row spacing, unsigned Q4.16); zero writes and unknown indexes are dropped.
//   Write only while idle.
//   Reset: both spacings return to 0.5 wavelength; queue and sequencer empty.
module beam_steering_phase_quantizer_top #(
  parameter int ARRAY_ROWS = 4,
  parameter int ARRAY_COLS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  bsq_pkg::bsq_in_t               in_data,
  output logic                           out_valid,
  output bsq_pkg::bsq_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [bsq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsq_pkg::SPACING_W-1:0]  cfg_wdata
);
  import bsq_pkg::*;

  logic [SPACING_W-1:0] spacing_x_r, spacing_x_nxt, spacing_y_r, spacing_y_nxt;
  logic                 push, pop, empty, full;
  bsq_cmd_t             push_data, head;

  always_comb begin
    spacing_x_nxt = spacing_x_r;
    spacing_y_nxt = spacing_y_r;
    if (cfg_we && cfg_wdata != '0) begin
      case (cfg_index)
        CFG_SPACING_X: spacing_x_nxt = cfg_wdata;
        CFG_SPACING_Y: spacing_y_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_x_r <= SPACING_RESET;
      spacing_y_r <= SPACING_RESET;
    end else begin
      spacing_x_r <= spacing_x_nxt;
      spacing_y_r <= spacing_y_nxt;
    end
  end

  bsq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  bsq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  bsq_back #(
    .ARRAY_ROWS (ARRAY_ROWS),
    .ARRAY_COLS (ARRAY_COLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .spacing_x (spacing_x_r),
    .spacing_y (spacing_y_r),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/bsq_front.sv
// Front end: takes directions, squares u and v, classifies against the unit circle.
// Depends on bsq_pkg; pushes classified commands into bsq_queue.
module bsq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bsq_pkg::bsq_in_t  in_data,
  input  logic              full,
  output logic              push,
  output bsq_pkg::bsq_cmd_t push_data
);
  import bsq_pkg::*;

  logic                    f1_v_r, f1_v_nxt;
  logic signed [DIR_W-1:0] u_r, v_r;
  logic signed [31:0]      uu_r, vv_r;
  logic signed [32:0]      mag_sq;
  logic                    take;

  assign busy   = f1_v_r && full;
  assign take   = start && !busy;
  assign push   = f1_v_r && !full;
  assign mag_sq = 33'(uu_r) + 33'(vv_r);

  assign push_data.dir_u    = u_r;
  assign push_data.dir_v    = v_r;
  assign push_data.rejected = mag_sq > UNIT_MAG_SQ;

  always_comb begin
    f1_v_nxt = f1_v_r;
    if (take) begin
      f1_v_nxt = 1'b1;
    end else if (push) begin
      f1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= f1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      u_r  <= in_data.dir_u;
      v_r  <= in_data.dir_v;
      uu_r <= 32'(in_data.dir_u) * 32'(in_data.dir_u);
      vv_r <= 32'(in_data.dir_v) * 32'(in_data.dir_v);
    end
  end

endmodule

FILE: rtl/core/bsq_queue.sv
// Short command queue between the front end and the element sequencer.
// Depends on bsq_pkg for the command type and depth.
module bsq_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bsq_pkg::bsq_cmd_t push_data,
  input  logic              pop,
  output bsq_pkg::bsq_cmd_t head,
  output logic              empty,
  output logic              full
);
  import bsq_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bsq_cmd_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty = count_r == '0;
  assign full  = count_r == CNT_W'(QUEUE_DEPTH);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/bsq_back.sv
// Back end: forms spacing-times-direction steps and walks the elements, one per cycle.
// Depends on bsq_pkg; pops commands from bsq_queue.
module bsq_back #(
  parameter int ARRAY_ROWS = 4,
  parameter int ARRAY_COLS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [bsq_pkg::SPACING_W-1:0]  spacing_x,
  input  logic [bsq_pkg::SPACING_W-1:0]  spacing_y,
  input  bsq_pkg::bsq_cmd_t              head,
  input  logic                           empty,
  output logic                           pop,
  output logic                           out_valid,
  output bsq_pkg::bsq_out_t              out_data
);
  import bsq_pkg::*;

  localparam int ELEMS = ARRAY_ROWS * ARRAY_COLS;
  localparam int TOTAL = (ELEMS > MAX_RESULTS) ? MAX_RESULTS : ELEMS;
  localparam int COL_W = (ARRAY_COLS > 1) ? $clog2(ARRAY_COLS) : 1;

  logic                     act_r, act_nxt;
  logic                     rej_r, rej_nxt;
  logic [3:0]               elem_r, elem_nxt;
  logic [COL_W-1:0]         col_r, col_nxt;
  logic [PHASE_W-1:0]       col_acc_r, col_acc_nxt, row_acc_r, row_acc_nxt;
  logic [PHASE_W-1:0]       sxu_r, syv_r, phase;
  logic signed [36:0]       sxu_full, syv_full;
  logic                     last;
  logic                     out_valid_r;
  bsq_out_t                 out_data_r, out_data_nxt;

  assign sxu_full = 37'($signed({1'b0, spacing_x})) * 37'(head.dir_u);
  assign syv_full = 37'($signed({1'b0, spacing_y})) * 37'(head.dir_v);

  assign last  = rej_r || (elem_r == 4'(TOTAL - 1));
  assign pop   = !empty && (!act_r || last);
  assign phase = PHASE_W'(0) - (col_acc_r + row_acc_r);

  always_comb begin
    out_data_nxt.element_index = rej_r ? 4'd0 : elem_r;
    out_data_nxt.phase_code    = rej_r ? 4'd0 : phase[PHASE_W-1 -: 4];
    out_data_nxt.rejected      = rej_r;
    out_data_nxt.last_element  = last;
  end

  always_comb begin
    act_nxt     = act_r;
    rej_nxt     = rej_r;
    elem_nxt    = elem_r;
    col_nxt     = col_r;
    col_acc_nxt = col_acc_r;
    row_acc_nxt = row_acc_r;
    if (pop) begin
      act_nxt     = 1'b1;
      rej_nxt     = head.rejected;
      elem_nxt    = '0;
      col_nxt     = '0;
      col_acc_nxt = '0;
      row_acc_nxt = '0;
    end else if (act_r && last) begin
      act_nxt = 1'b0;
    end else if (act_r) begin
      elem_nxt = elem_r + 1'b1;
      if (col_r == COL_W'(ARRAY_COLS - 1)) begin
        col_nxt     = '0;
        col_acc_nxt = '0;
        row_acc_nxt = row_acc_r + syv_r;
      end else begin
        col_nxt     = col_r + 1'b1;
        col_acc_nxt = col_acc_r + sxu_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      out_valid_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    rej_r      <= rej_nxt;
    elem_r     <= elem_nxt;
    col_r      <= col_nxt;
    col_acc_r  <= col_acc_nxt;
    row_acc_r  <= row_acc_nxt;
    out_data_r <= out_data_nxt;
    if (pop) begin
      sxu_r <= sxu_full[PHASE_W-1:0];
      syv_r <= syv_full[PHASE_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_rej_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rejected |-> out_data.last_element && out_data.element_index == 4'd0)
    else $error("rejected result is not a single last result");

  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_element |=> out_valid)
    else $error("gap inside an element burst");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_element |=>
      out_data.element_index == $past(out_data.element_index) + 4'd1)
    else $error("element index did not advance by one");

endmodule
